/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define HBOX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Expression that must never be true.
`define HBOX_ASSERT_NEVER(label, expr, msg) \
  `HBOX_ASSERT(label, !(expr), msg)

`endif

/* design/hbox_pkg.sv */
package hbox_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 16;
  localparam int DIM_BITS   = COORD_BITS - 1;
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int SUM_W      = COORD_BITS + 1;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_QRY = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic        [DIM_BITS-1:0]   width;
    logic        [DIM_BITS-1:0]   height;
  } box_t;

  // Request travelling down the cell row, with the flags it gathers.
  typedef struct packed {
    logic             valid;
    logic [1:0]       action;
    box_t             box;
    logic             placed;
    logic             hit;
    logic [CNT_W-1:0] removed;
  } token_t;

endpackage

/* design/hbox_cell.sv */
module hbox_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hbox_pkg::token_t tok_i,
  output hbox_pkg::token_t tok_o
);
  import hbox_pkg::*;

  token_t tok_d, tok_q;
  logic   valid_d, valid_q;
  logic   wr_en;
  box_t   box_q;

  logic                    same;
  logic                    ovl;
  logic signed [SUM_W-1:0] a_l, a_r, a_t, a_b;
  logic signed [SUM_W-1:0] b_l, b_r, b_t, b_b;
  logic signed [SUM_W-1:0] lo_x, hi_x, lo_y, hi_y;

  // Edges widened by one bit so that edge plus size cannot overflow.
  always_comb begin
    a_l  = SUM_W'(box_q.left);
    a_t  = SUM_W'(box_q.top);
    b_l  = SUM_W'(tok_i.box.left);
    b_t  = SUM_W'(tok_i.box.top);
    a_r  = a_l + $signed({{(SUM_W-DIM_BITS){1'b0}}, box_q.width});
    a_b  = a_t + $signed({{(SUM_W-DIM_BITS){1'b0}}, box_q.height});
    b_r  = b_l + $signed({{(SUM_W-DIM_BITS){1'b0}}, tok_i.box.width});
    b_b  = b_t + $signed({{(SUM_W-DIM_BITS){1'b0}}, tok_i.box.height});
    lo_x = (a_l > b_l) ? a_l : b_l;
    hi_x = (a_r < b_r) ? a_r : b_r;
    lo_y = (a_t > b_t) ? a_t : b_t;
    hi_y = (a_b < b_b) ? a_b : b_b;
    ovl  = (lo_x < hi_x) && (lo_y < hi_y);
    same = (box_q == tok_i.box);
  end

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    wr_en   = 1'b0;
    if (tok_i.valid) begin
      case (tok_i.action)
        ACT_ADD: begin
          if (!tok_i.placed && !valid_q) begin
            valid_d      = 1'b1;
            wr_en        = 1'b1;
            tok_d.placed = 1'b1;
          end
        end
        ACT_DEL: begin
          if (valid_q && same) begin
            valid_d       = 1'b0;
            tok_d.removed = tok_i.removed + CNT_W'(1);
          end
        end
        ACT_QRY: begin
          if (valid_q && ovl) begin
            tok_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      valid_q <= valid_d;
    end
  end

  // Box payload: no reset, only read behind its valid bit.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      box_q <= tok_i.box;
    end
  end

  assign tok_o = tok_q;

endmodule

/* design/hitbox_overlap_table.sv */
// The request passes through the row of cells, one cell per cycle, and the result strobe is
// registered from the last cell's output. No new start is taken while a request is in the row;
// the next start is taken in the strobe cycle.
// The result strobe is high for one cycle only; the receiver cannot stall.
// Reset (async, active low) clears all slot valid bits, the count and busy; stored boxes
// are left as they are.
module hitbox_overlap_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic signed [hbox_pkg::COORD_BITS-1:0] box_left_i,
  input  logic signed [hbox_pkg::COORD_BITS-1:0] box_top_i,
  input  logic [hbox_pkg::DIM_BITS-1:0]       box_width_i,
  input  logic [hbox_pkg::DIM_BITS-1:0]       box_height_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic                                dropped_full_o,
  output logic [hbox_pkg::CNT_W-1:0]          removed_count_o,
  output logic [hbox_pkg::CNT_W-1:0]          entry_count_o
);
  import hbox_pkg::*;

  token_t tok [MAX_BOXES+1];
  token_t tail;

  logic             busy_d, busy_q;
  logic             done_d, done_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             hit_q, drop_q;
  logic [CNT_W-1:0] removed_q;
  logic             drop_d;

  always_comb begin
    tok[0].valid      = start && !busy_q;
    tok[0].action     = action_i;
    tok[0].box.left   = box_left_i;
    tok[0].box.top    = box_top_i;
    tok[0].box.width  = box_width_i;
    tok[0].box.height = box_height_i;
    tok[0].placed     = 1'b0;
    tok[0].hit        = 1'b0;
    tok[0].removed    = '0;
  end

  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    hbox_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  assign tail = tok[MAX_BOXES];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    count_d = count_q;
    drop_d  = 1'b0;
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end
    if (tail.valid) begin
      busy_d = 1'b0;
      done_d = 1'b1;
      case (tail.action)
        ACT_ADD: begin
          drop_d  = !tail.placed;
          count_d = count_q + CNT_W'(tail.placed);
        end
        ACT_DEL: count_d = count_q - tail.removed;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      hit_q     <= tail.hit;
      drop_q    <= drop_d;
      removed_q <= tail.removed;
    end
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign dropped_full_o  = drop_q;
  assign removed_count_o = removed_q;
  assign entry_count_o   = count_q;

endmodule

/* design/hbox_checker.sv */
`include "assert_macros.svh"

module hbox_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic                       hit_o,
  input logic                       dropped_full_o,
  input logic [hbox_pkg::CNT_W-1:0] removed_count_o,
  input logic [hbox_pkg::CNT_W-1:0] entry_count_o
);
  import hbox_pkg::*;

  logic accept;
  assign accept = start && !busy;

  `HBOX_ASSERT(a_busy_after_accept, accept |=> busy, "busy not raised after transfer")
  `HBOX_ASSERT(a_result_time, accept |-> ##(MAX_BOXES+1) done_o, "result strobe late or missing")
  `HBOX_ASSERT_NEVER(a_done_busy, done_o && busy, "result shown while still busy")
  `HBOX_ASSERT_NEVER(a_count_range, done_o && (entry_count_o > CNT_W'(MAX_BOXES)), "count overrun")
  `HBOX_ASSERT_NEVER(a_one_flag, done_o && hit_o && (dropped_full_o || (removed_count_o != '0)), "flags of different actions together")

endmodule

bind hitbox_overlap_table hbox_checker u_hbox_checker (.*);
